// ----- src/sketch_edge_tone_filter_defines.svh -----
// Assertion helpers shared by the sketch filter modules.
`ifndef SKETCH_EDGE_TONE_FILTER_DEFINES_SVH
`define SKETCH_EDGE_TONE_FILTER_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define ETE_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while in reset.
`define ETE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/ete_pkg.sv -----
package ete_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int MAX_HEIGHT = 4096;
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int IMG_W_W    = 11;
  localparam int IMG_H_W    = 13;
  localparam int CFG_W      = 13;
  localparam int PX_W       = 24;

  localparam logic [0:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [0:0] REG_IMAGE_HEIGHT = 1'b1;

  localparam logic [IMG_W_W-1:0] WIDTH_RST  = IMG_W_W'(640);
  localparam logic [IMG_H_W-1:0] HEIGHT_RST = IMG_H_W'(480);

  // queue sizes (powers of two)
  localparam int MID_DEPTH = 16;
  localparam int MID_PTR_W = $clog2(MID_DEPTH);
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 32;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // four quotient / root bits per stage
  localparam int HDIV_STAGES = 4;
  localparam int BK_STAGES   = 19;
  localparam int BK_LAST     = BK_STAGES - 1;

  // reciprocals: floor(x/3) = x*GRAY_RECIP >> 19, x = sum << 8
  localparam logic [17:0] GRAY_RECIP = 18'd174763;
  localparam logic [19:0] NINE_RECIP = 20'd932068;   // >> 23
  localparam logic [20:0] T_RECIP    = 21'd2033602;  // >> 26, divides by 33
  localparam logic [15:0] KNEE       = 16'd32768;

  typedef struct packed {
    logic [15:0] gray;
    logic [15:0] hue;
  } tone_px_t;

  typedef struct packed {
    tone_px_t cur;
    tone_px_t above;
    tone_px_t left;
    logic     first_row;
    logic     first_col;
    logic     frame_end;
  } ete_item_t;

  typedef struct packed {
    logic [7:0] sketch_value;
    logic       frame_end;
  } ete_res_t;

  typedef struct packed {
    logic [10:0] rem;
    logic [10:0] dvs;
    logic [15:0] quo;
  } hdiv_t;

  typedef struct packed {
    logic [31:0] rad;
    logic [17:0] rem;
    logic [15:0] root;
  } isq_t;

  function automatic logic [15:0] gray_of(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    logic [9:0]  s;
    logic [27:0] p;
    s = 10'(a) + 10'(b) + 10'(c);
    p = 28'(s) * 28'(GRAY_RECIP);
    return p[26:11];
  endfunction

  // sector numerator and 6*delta; a grey pixel gets 0/6 so the quotient is 0
  function automatic hdiv_t hue_init(logic [7:0] a, logic [7:0] b, logic [7:0] c);
    hdiv_t              r;
    logic [7:0]         mx;
    logic [7:0]         mn;
    logic [7:0]         dl;
    logic signed [12:0] ra;
    logic signed [12:0] gb;
    logic signed [12:0] bc;
    logic signed [12:0] ds;
    logic signed [12:0] n;
    mx = (a > b) ? a : b;
    mn = (a < b) ? a : b;
    if (c > mx) mx = c;
    if (c < mn) mn = c;
    dl = mx - mn;
    ra = signed'({5'b0, a});
    gb = signed'({5'b0, b});
    bc = signed'({5'b0, c});
    ds = signed'({5'b0, dl});
    priority if (mx == a) begin
      n = gb - bc;
    end else if (mx == b) begin
      n = bc - ra + (ds <<< 1);
    end else begin
      n = ra - gb + (ds <<< 2);
    end
    if (n < 0) n = n + ds * 13'sd6;
    r.quo = '0;
    if (dl == 8'd0) begin
      r.rem = '0;
      r.dvs = 11'd6;
    end else begin
      r.rem = n[10:0];
      r.dvs = 11'(dl) * 11'd6;
    end
    return r;
  endfunction

  function automatic hdiv_t hdiv_steps(hdiv_t s);
    hdiv_t       r;
    logic [11:0] sh;
    r = s;
    for (int i = 0; i < 4; i++) begin
      sh = {r.rem, 1'b0};
      if (sh >= {1'b0, r.dvs}) begin
        r.rem = 11'(sh - {1'b0, r.dvs});
        r.quo = {r.quo[14:0], 1'b1};
      end else begin
        r.rem = sh[10:0];
        r.quo = {r.quo[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  function automatic isq_t isq_steps(isq_t s);
    isq_t        r;
    logic [19:0] acc;
    logic [19:0] trial;
    r = s;
    for (int i = 0; i < 4; i++) begin
      acc   = {r.rem, r.rad[31:30]};
      trial = {2'b00, r.root, 2'b01};
      if (acc >= trial) begin
        r.rem  = 18'(acc - trial);
        r.root = {r.root[14:0], 1'b1};
      end else begin
        r.rem  = acc[17:0];
        r.root = {r.root[14:0], 1'b0};
      end
      r.rad = {r.rad[29:0], 2'b00};
    end
    return r;
  endfunction

endpackage

// ----- src/sketch_edge_tone_filter.sv -----
// Channel   | Direction | Handshake        | Payload
// pixel in  | in        | push / full      | chan_a_i, chan_b_i, chan_c_i
// sketch    | out       | empty / pop      | sketch_value_o, frame_end_o
// config    | in        | cfg_we_i         | cfg_idx_i, cfg_wdata_i
//
// One pixel per clock sustained while full is low; both pipelines run without stalling.
// The front takes 16 pixels beyond what the back has taken, the back 32 results
// beyond those popped; full and the issue to the back follow these credit counts.
// Reset clears counters, queues and pipeline valids; the line buffer is not cleared.
`include "sketch_edge_tone_filter_defines.svh"

module sketch_edge_tone_filter
  import ete_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [0:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             push,
  output logic             full,
  input  logic [7:0]       chan_a_i,
  input  logic [7:0]       chan_b_i,
  input  logic [7:0]       chan_c_i,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       sketch_value_o,
  output logic             frame_end_o
);

  logic      accept;
  logic      item_valid;
  ete_item_t item;
  logic      issue;
  logic      res_valid;
  ete_res_t  res;
  logic      out_pop;

  ete_item_t            mid_q [MID_DEPTH];
  logic [MID_PTR_W-1:0] mid_wr_q, mid_rd_q;
  logic [MID_CNT_W-1:0] mid_cnt_q, front_used_q;

  ete_res_t             out_q [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] out_wr_q, out_rd_q;
  logic [OUT_CNT_W-1:0] out_cnt_q, out_used_q;

  assign full    = (front_used_q == MID_CNT_W'(MID_DEPTH));
  assign accept  = push && !full;
  assign issue   = (mid_cnt_q != '0) && (32'(out_used_q) < OUT_DEPTH);
  assign empty   = (out_cnt_q == '0);
  assign out_pop = pop && !empty;

  ete_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .accept_i     (accept),
    .chan_a_i     (chan_a_i),
    .chan_b_i     (chan_b_i),
    .chan_c_i     (chan_c_i),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  ete_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (issue),
    .item_i      (mid_q[mid_rd_q]),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_wr_q     <= '0;
      mid_rd_q     <= '0;
      mid_cnt_q    <= '0;
      front_used_q <= '0;
      out_wr_q     <= '0;
      out_rd_q     <= '0;
      out_cnt_q    <= '0;
      out_used_q   <= '0;
    end else begin
      if (item_valid) mid_wr_q <= mid_wr_q + 1'b1;
      if (issue)      mid_rd_q <= mid_rd_q + 1'b1;
      mid_cnt_q    <= mid_cnt_q + MID_CNT_W'(item_valid) - MID_CNT_W'(issue);
      front_used_q <= front_used_q + MID_CNT_W'(accept) - MID_CNT_W'(issue);
      if (res_valid) out_wr_q <= out_wr_q + 1'b1;
      if (out_pop)   out_rd_q <= out_rd_q + 1'b1;
      out_cnt_q  <= out_cnt_q + OUT_CNT_W'(res_valid) - OUT_CNT_W'(out_pop);
      out_used_q <= out_used_q + OUT_CNT_W'(issue) - OUT_CNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_valid) mid_q[mid_wr_q] <= item;
    if (res_valid)  out_q[out_wr_q] <= res;
  end

  assign sketch_value_o = out_q[out_rd_q].sketch_value;
  assign frame_end_o    = out_q[out_rd_q].frame_end;

  `ETE_ASSERT_IMPL(a_mid_no_overflow, item_valid && !issue, mid_cnt_q != MID_CNT_W'(MID_DEPTH), "mid queue overflow")
  `ETE_ASSERT_IMPL(a_out_no_overflow, res_valid && !out_pop, out_cnt_q != OUT_CNT_W'(OUT_DEPTH), "output queue overflow")
  `ETE_ASSERT_IMPL(a_mid_credit, 1'b1, mid_cnt_q <= front_used_q, "mid queue holds more than credited")
  `ETE_ASSERT_IMPL(a_out_credit, 1'b1, out_cnt_q <= out_used_q, "output queue holds more than credited")

endmodule

// ----- src/ete_ram.sv -----
module ete_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read-first on a same-address collision
  always_ff @(posedge clk_i) begin
    if (re_i) rdata_o <= mem_q[raddr_i];
    if (we_i) mem_q[waddr_i] <= wdata_i;
  end

endmodule

// ----- src/ete_front.sv -----
`include "sketch_edge_tone_filter_defines.svh"

module ete_front
  import ete_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_wdata_i,
  input  logic               accept_i,
  input  logic [7:0]         chan_a_i,
  input  logic [7:0]         chan_b_i,
  input  logic [7:0]         chan_c_i,
  output logic               item_valid_o,
  output ete_item_t          item_o
);

  typedef struct packed {
    logic [15:0] cur_gray;
    logic [15:0] above_gray;
    hdiv_t       cur_div;
    hdiv_t       above_div;
    logic        first_row;
    logic        first_col;
    logic        frame_end;
  } hstage_t;

  logic [IMG_W_W-1:0] width_q;
  logic [IMG_H_W-1:0] height_q;
  logic [COL_W-1:0]   col_q, col_d, wm1;
  logic [ROW_W-1:0]   row_q, row_d, hm1;
  logic               row_end, frame_end;

  logic               f0_valid_q;
  logic [PX_W-1:0]    f0_px_q;
  logic               f0_first_row_q, f0_first_col_q, f0_frame_end_q;
  logic [PX_W-1:0]    above_px;

  logic               dv_valid_q [HDIV_STAGES+1];
  hstage_t            dv_q       [HDIV_STAGES+1];
  tone_px_t           last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RST;
      height_q <= HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= cfg_wdata_i[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= cfg_wdata_i[IMG_H_W-1:0];
      endcase
    end
  end

  // out-of-range sizes clamp to 1..max
  always_comb begin
    if (width_q == '0) begin
      wm1 = '0;
    end else if (32'(width_q) > MAX_WIDTH) begin
      wm1 = COL_W'(MAX_WIDTH - 1);
    end else begin
      wm1 = COL_W'(width_q - 1'b1);
    end
    if (height_q == '0) begin
      hm1 = '0;
    end else if (32'(height_q) > MAX_HEIGHT) begin
      hm1 = ROW_W'(MAX_HEIGHT - 1);
    end else begin
      hm1 = ROW_W'(height_q - 1'b1);
    end
    row_end   = col_q >= wm1;
    frame_end = row_end && (row_q >= hm1);
    col_d     = row_end ? '0 : col_q + 1'b1;
    row_d     = row_q;
    if (row_end) row_d = frame_end ? '0 : row_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  ete_ram #(
    .WIDTH (PX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk_i   (clk_i),
    .we_i    (accept_i),
    .waddr_i (col_q),
    .wdata_i ({chan_c_i, chan_b_i, chan_a_i}),
    .re_i    (accept_i),
    .raddr_i (col_q),
    .rdata_o (above_px)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f0_valid_q <= 1'b0;
      for (int k = 0; k <= HDIV_STAGES; k++) dv_valid_q[k] <= 1'b0;
      last_q <= '0;
    end else begin
      f0_valid_q    <= accept_i;
      dv_valid_q[0] <= f0_valid_q;
      for (int k = 1; k <= HDIV_STAGES; k++) dv_valid_q[k] <= dv_valid_q[k-1];
      // left neighbour of the next item
      if (dv_valid_q[HDIV_STAGES]) begin
        last_q.gray <= dv_q[HDIV_STAGES].cur_gray;
        last_q.hue  <= dv_q[HDIV_STAGES].cur_div.quo;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    f0_px_q        <= {chan_c_i, chan_b_i, chan_a_i};
    f0_first_row_q <= (row_q == '0);
    f0_first_col_q <= (col_q == '0);
    f0_frame_end_q <= frame_end;

    dv_q[0].cur_gray   <= gray_of(f0_px_q[7:0], f0_px_q[15:8], f0_px_q[23:16]);
    dv_q[0].above_gray <= gray_of(above_px[7:0], above_px[15:8], above_px[23:16]);
    dv_q[0].cur_div    <= hue_init(f0_px_q[7:0], f0_px_q[15:8], f0_px_q[23:16]);
    dv_q[0].above_div  <= hue_init(above_px[7:0], above_px[15:8], above_px[23:16]);
    dv_q[0].first_row  <= f0_first_row_q;
    dv_q[0].first_col  <= f0_first_col_q;
    dv_q[0].frame_end  <= f0_frame_end_q;
    for (int k = 1; k <= HDIV_STAGES; k++) begin
      dv_q[k].cur_gray   <= dv_q[k-1].cur_gray;
      dv_q[k].above_gray <= dv_q[k-1].above_gray;
      dv_q[k].cur_div    <= hdiv_steps(dv_q[k-1].cur_div);
      dv_q[k].above_div  <= hdiv_steps(dv_q[k-1].above_div);
      dv_q[k].first_row  <= dv_q[k-1].first_row;
      dv_q[k].first_col  <= dv_q[k-1].first_col;
      dv_q[k].frame_end  <= dv_q[k-1].frame_end;
    end
  end

  assign item_valid_o       = dv_valid_q[HDIV_STAGES];
  assign item_o.cur.gray    = dv_q[HDIV_STAGES].cur_gray;
  assign item_o.cur.hue     = dv_q[HDIV_STAGES].cur_div.quo;
  assign item_o.above.gray  = dv_q[HDIV_STAGES].above_gray;
  assign item_o.above.hue   = dv_q[HDIV_STAGES].above_div.quo;
  assign item_o.left        = last_q;
  assign item_o.first_row   = dv_q[HDIV_STAGES].first_row;
  assign item_o.first_col   = dv_q[HDIV_STAGES].first_col;
  assign item_o.frame_end   = dv_q[HDIV_STAGES].frame_end;

  `ETE_ASSERT_NEXT(a_frame_wrap, accept_i && frame_end, (col_q == '0) && (row_q == '0), "frame end did not wrap counters")
  `ETE_ASSERT_IMPL(a_col_bound, 1'b1, 32'(col_q) < MAX_WIDTH, "column counter out of range")
  `ETE_ASSERT_NEXT(a_flags_follow, accept_i, f0_valid_q && (f0_first_col_q == ($past(col_q) == '0)), "stage 0 flags lost")

endmodule

// ----- src/ete_back.sv -----
module ete_back
  import ete_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  ete_item_t item_i,
  output logic      res_valid_o,
  output ete_res_t  res_o
);

  typedef struct packed {
    logic        frame_end;
    logic        first_row;
    logic        first_col;
    logic [15:0] gray;
    logic [19:0] xa;
    logic [19:0] xl;
    logic [15:0] dx;
    logic [15:0] dy;
    isq_t        isq;
    logic [20:0] xmix;
    logic [15:0] lo_v;
    logic        hi;
    logic [7:0]  res;
  } bk_t;

  function automatic logic [19:0] diff_sum(tone_px_t p, tone_px_t q);
    logic [15:0] dg;
    logic [15:0] dh;
    logic [16:0] alt;
    dg  = (p.gray > q.gray) ? p.gray - q.gray : q.gray - p.gray;
    dh  = (p.hue > q.hue) ? p.hue - q.hue : q.hue - p.hue;
    alt = 17'h10000 - 17'(dh);
    // hue is circular: take the shorter way round
    if (alt < 17'(dh)) dh = alt[15:0];
    return {1'b0, dg, 3'b000} + 20'(dh);
  endfunction

  logic valid_q [BK_STAGES];
  bk_t  bk_q    [BK_STAGES];
  bk_t  nxt     [BK_STAGES];

  always_comb begin
    logic [39:0] pa, pl;
    logic [32:0] ssum;
    logic [47:0] pt;
    logic [31:0] ps;
    logic [15:0] sd;
    logic [16:0] vv, ww;

    // diffs against the pixel above and the left one
    nxt[0]           = bk_q[0];
    nxt[0].frame_end = item_i.frame_end;
    nxt[0].first_row = item_i.first_row;
    nxt[0].first_col = item_i.first_col;
    nxt[0].gray      = item_i.cur.gray;
    nxt[0].xa        = diff_sum(item_i.cur, item_i.above);
    nxt[0].xl        = diff_sum(item_i.cur, item_i.left);

    // weighted sum / 9
    nxt[1]    = bk_q[0];
    pa        = 40'(bk_q[0].xa) * 40'(NINE_RECIP);
    pl        = 40'(bk_q[0].xl) * 40'(NINE_RECIP);
    nxt[1].dx = bk_q[0].first_row ? '0 : pa[38:23];
    nxt[1].dy = bk_q[0].first_col ? '0 : pl[38:23];

    nxt[2]          = bk_q[1];
    ssum            = 33'(bk_q[1].dx) * 33'(bk_q[1].dx) + 33'(bk_q[1].dy) * 33'(bk_q[1].dy);
    nxt[2].isq.rad  = ssum[32:1];
    nxt[2].isq.rem  = '0;
    nxt[2].isq.root = '0;

    for (int k = 3; k <= 6; k++) begin
      nxt[k]     = bk_q[k-1];
      nxt[k].isq = isq_steps(bk_q[k-1].isq);
    end

    // inverted gray 10 : gradient 23
    nxt[7]      = bk_q[6];
    nxt[7].xmix = 21'd10 * (21'h10000 - 21'(bk_q[6].gray)) + 21'd23 * 21'(bk_q[6].isq.root);

    nxt[8]          = bk_q[7];
    pt              = 48'(bk_q[7].xmix) * 48'(T_RECIP);
    nxt[8].isq.rad  = {pt[41:26], 16'h0000};
    nxt[8].isq.rem  = '0;
    nxt[8].isq.root = '0;

    for (int k = 9; k <= 12; k++) begin
      nxt[k]     = bk_q[k-1];
      nxt[k].isq = isq_steps(bk_q[k-1].isq);
    end

    // tone curve: square below the knee, root above
    nxt[13]          = bk_q[12];
    sd               = bk_q[12].isq.root - KNEE;
    ps               = 32'(bk_q[12].isq.root) * 32'(bk_q[12].isq.root);
    nxt[13].hi       = bk_q[12].isq.root > KNEE;
    nxt[13].lo_v     = ps[30:15];
    nxt[13].isq.rad  = {2'b00, sd[14:0], 15'h0000};
    nxt[13].isq.rem  = '0;
    nxt[13].isq.root = '0;

    for (int k = 14; k <= 17; k++) begin
      nxt[k]     = bk_q[k-1];
      nxt[k].isq = isq_steps(bk_q[k-1].isq);
    end

    nxt[18]     = bk_q[17];
    vv          = bk_q[17].hi ? 17'(KNEE) + 17'(bk_q[17].isq.root) : 17'(bk_q[17].lo_v);
    ww          = 17'h10000 - vv;
    nxt[18].res = ww[16] ? 8'hFF : ww[15:8];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BK_STAGES; k++) valid_q[k] <= 1'b0;
    end else begin
      valid_q[0] <= in_valid_i;
      for (int k = 1; k < BK_STAGES; k++) valid_q[k] <= valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < BK_STAGES; k++) bk_q[k] <= nxt[k];
  end

  assign res_valid_o        = valid_q[BK_LAST];
  assign res_o.sketch_value = bk_q[BK_LAST].res;
  assign res_o.frame_end    = bk_q[BK_LAST].frame_end;

endmodule
